// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on i_clk and i_rst_n being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge while out of reset.
`define RDP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define RDP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RDP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdp_pkg.sv =====
// Package for the palette converter: request codes, phase codes, shared types,
// and the index-folding table used by the palette memory. No dependencies.
package rdp_pkg;

    localparam int DEF_PALETTE_DEPTH = 256;
    localparam int ADDR_SPACE        = 256;

    localparam logic [1:0] REQ_RD  = 2'd0;
    localparam logic [1:0] REQ_WR  = 2'd1;
    localparam logic [1:0] REQ_PIX = 2'd2;

    localparam logic [1:0] SEL_ADDR0 = 2'd0;
    localparam logic [1:0] SEL_PAL   = 2'd1;
    localparam logic [1:0] SEL_ADDR2 = 2'd2;
    localparam logic [1:0] SEL_OVL   = 2'd3;

    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    typedef logic [ADDR_SPACE-1:0][7:0] t_mod_tab;

    // write port of a color store
    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [23:0] data;
    } t_store_wr;

    // index modulo depth, built by counting so no divider is inferred
    function automatic t_mod_tab rdp_mod_table(input int depth);
        t_mod_tab tab;
        int       m;
        m = 0;
        for (int i = 0; i < ADDR_SPACE; i++) begin
            tab[i] = 8'(m);
            m = (m == depth - 1) ? 0 : m + 1;
        end
        return tab;
    endfunction

endpackage

// ===== rtl/rdp_if.sv =====
// Request and response channel interfaces of the palette converter.
// Depends on nothing; payload widths are fixed by the item fields.
interface rdp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic [7:0] pixel_index;
    logic [1:0] overlay_sel;

    modport source(output valid, req_type, reg_sel, write_data, pixel_index, overlay_sel,
                   input ready);
    modport sink(input valid, req_type, reg_sel, write_data, pixel_index, overlay_sel,
                 output ready);
endinterface

interface rdp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       display_changed;

    modport source(output valid, read_data, red, green, blue, display_changed,
                   input ready);
    modport sink(input valid, read_data, red, green, blue, display_changed,
                 output ready);
endinterface

// ===== rtl/rdp_palette_mem.sv =====
// Palette store: synchronous single-write, single-read memory, registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses rdp_pkg.
module rdp_palette_mem #(
    parameter int PALETTE_DEPTH = rdp_pkg::DEF_PALETTE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdp_pkg::t_store_wr i_wr,
    input  logic              i_rd_en,
    input  logic [7:0]        i_rd_addr,
    output logic [23:0]       o_rd_data
);
    import rdp_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam t_mod_tab ModTab = rdp_mod_table(PALETTE_DEPTH);

    logic [23:0]              mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] r_valid;
    logic [23:0]              r_q;
    logic                     r_qv;
    logic [AW-1:0]            widx;
    logic [AW-1:0]            ridx;

    assign widx = ModTab[i_wr.addr][AW-1:0];
    assign ridx = ModTab[i_rd_addr][AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[widx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q <= mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[widx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_qv <= r_valid[ridx];
            end
        end
    end

    assign o_rd_data = r_qv ? r_q : 24'd0;

endmodule

// ===== rtl/rdp_overlay_store.sv =====
// Overlay store: four 24-bit color entries in flops, cleared at reset,
// one write and one registered read per cycle. Uses rdp_pkg.
module rdp_overlay_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdp_pkg::t_store_wr i_wr,
    input  logic              i_rd_en,
    input  logic [1:0]        i_rd_addr,
    output logic [23:0]       o_rd_data
);
    import rdp_pkg::*;

    logic [23:0] r_ent [4];
    logic [23:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_ent[i] <= 24'd0;
            end
            r_q <= 24'd0;
        end else begin
            if (i_wr.en) begin
                r_ent[i_wr.addr[1:0]] <= i_wr.data;
            end
            if (i_rd_en) begin
                r_q <= r_ent[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q;

endmodule

// ===== rtl/ramdac_palette_with_overlay.sv =====
// Palette converter top: register port sequencing and pixel lookup.
// A result passes the memory read register with the lookup stage, then the output register.
// Throughput: one request per cycle while o_rsp is not stalled, set by the single palette memory port.
// Reset: address, phase and held bytes clear; palette valid bits and overlay entries
// clear at once, so no clearing pass is needed and requests are taken right after reset.
`include "assert_macros.svh"

module ramdac_palette_with_overlay #(
    parameter int PALETTE_DEPTH = rdp_pkg::DEF_PALETTE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rdp_req_if.sink   i_req,
    rdp_rsp_if.source o_rsp
);
    import rdp_pkg::*;

    // register port state
    logic [7:0] r_addr, n_addr;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;

    // lookup stage (memory data arrives here)
    logic       r_v1;
    logic [1:0] r_req1;
    logic       r_is_addr1;
    logic       r_use_ovl1;
    logic [1:0] r_phase1;
    logic [7:0] r_addr1;
    logic       r_chg1;

    // output register
    logic       r_ov;
    logic [7:0] r_rd, r_red, r_grn, r_blu;
    logic       r_chg;

    logic        acc, adv1;
    logic        is_addr, is_ovl, is_reg, commit;
    t_store_wr   pal_wr, ovl_wr;
    logic [7:0]  pal_raddr;
    logic [1:0]  ovl_raddr;
    logic [23:0] pal_q, ovl_q, color;
    logic [7:0]  phase_byte;
    logic        rsp_zero, blue_acc, wr_ok;

    assign adv1        = r_v1 && (!r_ov || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_v1 || adv1);
    assign acc         = i_req.valid && i_req.ready;

    assign is_addr = (i_req.reg_sel == SEL_ADDR0) || (i_req.reg_sel == SEL_ADDR2);
    assign is_ovl  = (i_req.reg_sel == SEL_OVL);
    assign is_reg  = (i_req.req_type == REQ_RD) || (i_req.req_type == REQ_WR);
    assign commit  = (i_req.req_type == REQ_WR) && !is_addr && (r_phase == PH_BLUE);

    always_comb begin
        pal_wr.en   = acc && commit && !is_ovl;
        pal_wr.addr = r_addr;
        pal_wr.data = {r_held0, r_held1, i_req.write_data};
        ovl_wr.en   = acc && commit && is_ovl;
        ovl_wr.addr = r_addr;
        ovl_wr.data = {r_held0, r_held1, i_req.write_data};
    end

    assign pal_raddr = (i_req.req_type == REQ_PIX) ? i_req.pixel_index : r_addr;
    assign ovl_raddr = (i_req.req_type == REQ_PIX) ? i_req.overlay_sel : r_addr[1:0];

    rdp_palette_mem #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (pal_wr),
        .i_rd_en  (acc),
        .i_rd_addr(pal_raddr),
        .o_rd_data(pal_q)
    );

    rdp_overlay_store u_ovl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (ovl_wr),
        .i_rd_en  (acc),
        .i_rd_addr(ovl_raddr),
        .o_rd_data(ovl_q)
    );

    // phase/address sequencing of the register port
    always_comb begin
        n_addr  = r_addr;
        n_phase = r_phase;
        n_held0 = r_held0;
        n_held1 = r_held1;
        if (acc && is_reg) begin
            if (is_addr) begin
                if (i_req.req_type == REQ_WR) begin
                    n_addr  = i_req.write_data;
                    n_phase = PH_RED;
                end
            end else begin
                if (i_req.req_type == REQ_WR) begin
                    if (r_phase == PH_RED) begin
                        n_held0 = i_req.write_data;
                    end
                    if (r_phase == PH_GREEN) begin
                        n_held1 = i_req.write_data;
                    end
                end
                if (r_phase == PH_BLUE) begin
                    n_phase = PH_RED;
                    n_addr  = r_addr + 8'd1;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 8'd0;
            r_phase <= PH_RED;
            r_held0 <= 8'd0;
            r_held1 <= 8'd0;
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_phase <= n_phase;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req1     <= i_req.req_type;
            r_is_addr1 <= is_addr;
            r_use_ovl1 <= (i_req.req_type == REQ_PIX) ? (i_req.overlay_sel != 2'd0) : is_ovl;
            r_phase1   <= r_phase;
            r_addr1    <= r_addr;
            r_chg1     <= commit && (!is_ovl || (r_addr[1:0] != 2'd0));
        end
    end

    assign color = r_use_ovl1 ? ovl_q : pal_q;

    always_comb begin
        case (r_phase1)
            PH_RED:   phase_byte = color[23:16];
            PH_GREEN: phase_byte = color[15:8];
            default:  phase_byte = color[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_rd  <= (r_req1 == REQ_RD) ? (r_is_addr1 ? r_addr1 : phase_byte) : 8'd0;
            r_red <= (r_req1 == REQ_PIX) ? color[23:16] : 8'd0;
            r_grn <= (r_req1 == REQ_PIX) ? color[15:8] : 8'd0;
            r_blu <= (r_req1 == REQ_PIX) ? color[7:0] : 8'd0;
            r_chg <= r_chg1;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.read_data       = r_rd;
    assign o_rsp.red             = r_red;
    assign o_rsp.green           = r_grn;
    assign o_rsp.blue            = r_blu;
    assign o_rsp.display_changed = r_chg;

    assign rsp_zero = (r_rd == 8'd0) && (r_red == 8'd0) && (r_grn == 8'd0) && (r_blu == 8'd0);
    assign blue_acc = acc && is_reg && !is_addr && (r_phase == PH_BLUE);
    assign wr_ok    = (r_phase == PH_BLUE) && !(pal_wr.en && ovl_wr.en);

    // a commit only comes from a write, which carries no read byte or color
    `RDP_ASSERT_IMP(a_chg_clean, r_ov && r_chg, rsp_zero, "display_changed with nonzero data")
    // a data transfer on the blue byte returns the phase to red
    `RDP_ASSERT_NXT(a_phase_wrap, blue_acc, r_phase == PH_RED, "phase did not wrap after blue")
    // stores are written only on the blue byte, and never both at once
    `RDP_ASSERT_IMP(a_wr_blue, pal_wr.en || ovl_wr.en, wr_ok, "store write outside blue phase")

endmodule
